// ===== src/info_frame_byte_stuffer_assert.svh =====
// Assertion macros for the information frame byte stuffer.
// Included by the checker module; depends on nothing else.
`ifndef INFO_FRAME_BYTE_STUFFER_ASSERT_SVH
`define INFO_FRAME_BYTE_STUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ifbs assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define IFBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ifbs assertion failed: next-cycle implication");

`endif

// ===== src/ifbs_pkg.sv =====
// Package for the information frame byte stuffer: shared types and constants.
// Used by ifbs_expand, ifbs_burst and the top level; depends on nothing.
`timescale 1ns / 1ps

package ifbs_pkg;

  localparam int unsigned MaxResults = 9;
  localparam int unsigned CountW     = 4;

  // Configuration register indexes (address bits [4:2]).
  localparam logic [2:0] RegFlag     = 3'd0;
  localparam logic [2:0] RegEscape   = 3'd1;
  localparam logic [2:0] RegFlagEsc  = 3'd2;
  localparam logic [2:0] RegEscEsc   = 3'd3;
  localparam logic [2:0] RegAddress  = 3'd4;
  localparam logic [2:0] RegCtrlZero = 3'd5;
  localparam logic [2:0] RegCtrlOne  = 3'd6;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] flag_escape_code;
    logic [7:0] escape_escape_code;
    logic [7:0] address_byte;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  // One expanded item: its line bytes in order, how many, and whether it closes a frame.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       closes;
  } burst_t;

endpackage

// ===== src/ifbs_expand.sv =====
// Combinational expansion of one payload item into its line bytes.
// Depends on ifbs_pkg.
`timescale 1ns / 1ps

module ifbs_expand (
  input  ifbs_pkg::cfg_t   cfg_i,
  input  logic [7:0]       check_i,
  input  logic [7:0]       data_byte_i,
  input  logic             first_byte_i,
  input  logic             last_byte_i,
  input  logic             seq_bit_i,
  output ifbs_pkg::burst_t burst_o,
  output logic [7:0]       check_o
);
  import ifbs_pkg::*;

  // Returns {two_bytes, byte0, byte1} for a stuffed byte.
  function automatic logic [16:0] stuff(input logic [7:0] b, input cfg_t c);
    logic [16:0] r;
    if (b == c.flag_byte) begin
      r = {1'b1, c.escape_byte, c.flag_escape_code};
    end else if (b == c.escape_byte) begin
      r = {1'b1, c.escape_byte, c.escape_escape_code};
    end else begin
      r = {1'b0, b, 8'h00};
    end
    return r;
  endfunction

  logic [7:0]        ctrl;
  logic [7:0]        new_check;
  logic [16:0]       data_st;
  logic [16:0]       bcc_st;
  logic [CountW-1:0] pos;

  always_comb begin
    ctrl      = seq_bit_i ? cfg_i.control_seq_one : cfg_i.control_seq_zero;
    new_check = (first_byte_i ? 8'h00 : check_i) ^ data_byte_i;
    data_st   = stuff(data_byte_i, cfg_i);
    bcc_st    = stuff(new_check, cfg_i);

    burst_o.bytes  = '0;
    burst_o.closes = last_byte_i;
    pos            = '0;

    if (first_byte_i) begin
      burst_o.bytes[0] = cfg_i.flag_byte;
      burst_o.bytes[1] = cfg_i.address_byte;
      burst_o.bytes[2] = ctrl;
      burst_o.bytes[3] = cfg_i.address_byte ^ ctrl;
      pos              = CountW'(4);
    end

    burst_o.bytes[pos] = data_st[15:8];
    if (data_st[16]) begin
      burst_o.bytes[pos + CountW'(1)] = data_st[7:0];
      pos                             = pos + CountW'(2);
    end else begin
      pos = pos + CountW'(1);
    end

    if (last_byte_i) begin
      burst_o.bytes[pos] = bcc_st[15:8];
      if (bcc_st[16]) begin
        burst_o.bytes[pos + CountW'(1)] = bcc_st[7:0];
        pos                             = pos + CountW'(2);
      end else begin
        pos = pos + CountW'(1);
      end
      burst_o.bytes[pos] = cfg_i.flag_byte;
      pos                = pos + CountW'(1);
    end

    burst_o.count = pos;
    check_o       = last_byte_i ? 8'h00 : new_check;
  end

endmodule

// ===== src/ifbs_burst.sv =====
// Burst register and output register: sends the bytes of one expanded item one per cycle unless stalled.
// Depends on ifbs_pkg.
`timescale 1ns / 1ps

module ifbs_burst (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ifbs_pkg::burst_t burst_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             frame_end_o
);
  import ifbs_pkg::*;

  logic [MaxResults-1:0][7:0] bytes_q;
  logic [CountW-1:0]          cnt_q;
  logic                       closes_q;
  logic [CountW-1:0]          idx_q;
  logic                       busy_q;
  logic                       out_valid_q;
  logic [7:0]                 out_byte_q;
  logic                       run_last_q;
  logic                       frame_end_q;
  logic                       out_ready;
  logic                       final_slot;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign final_slot = (idx_q == cnt_q - CountW'(1));
  assign ready_o    = !busy_q || (out_ready && final_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_q <= busy_q;
      end
      if (load_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (out_ready && busy_q) begin
        if (final_slot) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q  <= burst_i.bytes;
      cnt_q    <= burst_i.count;
      closes_q <= burst_i.closes;
    end
    if (out_ready && busy_q) begin
      out_byte_q  <= bytes_q[idx_q];
      run_last_q  <= final_slot;
      frame_end_q <= final_slot && closes_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

endmodule

// ===== src/info_frame_byte_stuffer.sv =====
// Top level of the information frame byte stuffer: register port, check byte, datapath.
// Depends on ifbs_pkg, ifbs_expand and ifbs_burst.
`timescale 1ns / 1ps

// The block turns payload bytes into the line stream of an information frame.
// A payload request marked first is preceded by the opening flag, the address,
// the control byte picked by the sequence bit and the header check (address XOR
// control); a request marked last is followed by the running XOR check of the
// frame, stuffed like data, and the closing flag, which is tagged with frame_end.
// Payload bytes equal to the flag or escape value go out as the escape byte plus
// its code. Each accepted request becomes a burst of line bytes: one for a plain
// byte, two for a stuffed byte, up to nine for a single-byte frame. The burst
// leaves one byte per cycle while the output is not stalled. A new request is
// accepted in the same cycle the previous burst hands over its final byte, so
// bursts follow each other with no gap; the first byte of a request passes through
// the burst register and then the output register. run_last marks the final byte
// of each request's burst. The seven 8-bit settings sit at byte addresses 0 to 24
// of the register port and should be written only while the block is idle; writes
// to addresses 28 to 31 are ignored and read back as zero.
module info_frame_byte_stuffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Payload requests.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic        seq_bit_i,
  // Line bytes.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        frame_end_o
);
  import ifbs_pkg::*;

  cfg_t       cfg_q;
  logic [7:0] check_q;
  logic [7:0] check_d;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       in_ready;
  logic       in_accept;
  burst_t     burst;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Settings reset to the usual HDLC-style values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte          <= 8'd126;
      cfg_q.escape_byte        <= 8'd125;
      cfg_q.flag_escape_code   <= 8'd94;
      cfg_q.escape_escape_code <= 8'd93;
      cfg_q.address_byte       <= 8'd3;
      cfg_q.control_seq_zero   <= 8'd0;
      cfg_q.control_seq_one    <= 8'd64;
    end else if (wr_en) begin
      case (reg_idx)
        RegFlag:     cfg_q.flag_byte          <= pwdata[7:0];
        RegEscape:   cfg_q.escape_byte        <= pwdata[7:0];
        RegFlagEsc:  cfg_q.flag_escape_code   <= pwdata[7:0];
        RegEscEsc:   cfg_q.escape_escape_code <= pwdata[7:0];
        RegAddress:  cfg_q.address_byte       <= pwdata[7:0];
        RegCtrlZero: cfg_q.control_seq_zero   <= pwdata[7:0];
        RegCtrlOne:  cfg_q.control_seq_one    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegFlag:     prdata = {24'h0, cfg_q.flag_byte};
      RegEscape:   prdata = {24'h0, cfg_q.escape_byte};
      RegFlagEsc:  prdata = {24'h0, cfg_q.flag_escape_code};
      RegEscEsc:   prdata = {24'h0, cfg_q.escape_escape_code};
      RegAddress:  prdata = {24'h0, cfg_q.address_byte};
      RegCtrlZero: prdata = {24'h0, cfg_q.control_seq_zero};
      RegCtrlOne:  prdata = {24'h0, cfg_q.control_seq_one};
      default:     prdata = 32'h0;
    endcase
  end

  assign in_stall_o = !in_ready;
  assign in_accept  = in_valid_i && in_ready;

  // The running frame check is updated when a request is accepted, so the next
  // request sees it at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= 8'h00;
    end else if (in_accept) begin
      check_q <= check_d;
    end
  end

  ifbs_expand u_expand (
    .cfg_i        (cfg_q),
    .check_i      (check_q),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .seq_bit_i    (seq_bit_i),
    .burst_o      (burst),
    .check_o      (check_d)
  );

  ifbs_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .burst_i     (burst),
    .ready_o     (in_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ===== src/ifbs_checker.sv =====
// Port-level checker for the information frame byte stuffer, bound to the top level.
// Depends on info_frame_byte_stuffer_assert.svh.
`timescale 1ns / 1ps
`include "info_frame_byte_stuffer_assert.svh"

module ifbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        run_last_o,
  input logic        frame_end_o
);

  // The closing flag always ends the burst of its request.
  `IFBS_ASSERT_IMP(a_end_is_last, clk_i, rst_ni, out_valid_o && frame_end_o, run_last_o)

  // A byte that is not the last of its burst is always followed by another one.
  `IFBS_ASSERT_NXT(a_burst_continues, clk_i, rst_ni, out_valid_o && !run_last_o, out_valid_o)

  // A stalled line byte is held with its tags.
  `IFBS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(run_last_o) && $stable(frame_end_o))

endmodule

bind info_frame_byte_stuffer ifbs_checker u_ifbs_checker (.*);
